FILE: rtl/bsp_pkg.sv
package bsp_pkg;

  localparam int CW = 32;          // coordinate width, Q16.16
  localparam int VW = 16;          // view component width, Q2.14
  localparam int PW = CW + VW;     // one coordinate times one view component
  localparam int DW = 52;          // corner distances and their differences, Q.30
  localparam int QB = 31;          // quotient bits of the edge fraction divider
  localparam int FB = 30;          // fraction bits of the edge parameter t
  localparam int NCORNER = 8;
  localparam int NEDGE = 12;

  typedef struct packed {
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
    logic signed [CW-1:0] plane_pos;
  } box_t;

  typedef struct packed {
    logic signed [CW-1:0] vert_x;
    logic signed [CW-1:0] vert_y;
    logic signed [CW-1:0] vert_z;
    logic [2:0]           vert_number;
    logic [7:0]           corner_code;
    logic                 no_polygon;
    logic                 last_vertex;
  } vert_t;

  // Vertex count and crossed edges in polygon order, first edge in the top nibble.
  typedef struct packed {
    logic [2:0]      count;
    logic [0:5][3:0] edges;
  } poly_t;

  // One polygon vertex on its way through the divider and the interpolator.
  typedef struct packed {
    logic [2:0][CW-1:0] pa;
    logic [2:0][CW-1:0] pb;
    logic [2:0]         num;
    logic [7:0]         code;
    logic               nopoly;
    logic               last;
  } vjob_t;

  // Bit 0 selects max x, bit 1 max y, bit 2 max z.
  function automatic logic [2:0] corner_sel(input logic [2:0] c);
    logic [2:0] s;
    case (c)
      3'd0: s = 3'd0;
      3'd1: s = 3'd1;
      3'd2: s = 3'd3;
      3'd3: s = 3'd2;
      3'd4: s = 3'd4;
      3'd5: s = 3'd5;
      3'd6: s = 3'd7;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] edge_a(input logic [3:0] e);
    logic [2:0] a;
    case (e)
      4'd0: a = 3'd0;
      4'd1: a = 3'd1;
      4'd2: a = 3'd2;
      4'd3: a = 3'd3;
      4'd4: a = 3'd4;
      4'd5: a = 3'd5;
      4'd6: a = 3'd6;
      4'd7: a = 3'd7;
      4'd8: a = 3'd0;
      4'd9: a = 3'd1;
      4'd10: a = 3'd2;
      4'd11: a = 3'd3;
      default: a = 3'd0;
    endcase
    return a;
  endfunction

  function automatic logic [2:0] edge_b(input logic [3:0] e);
    logic [2:0] b;
    case (e)
      4'd0: b = 3'd1;
      4'd1: b = 3'd2;
      4'd2: b = 3'd3;
      4'd3: b = 3'd0;
      4'd4: b = 3'd5;
      4'd5: b = 3'd6;
      4'd6: b = 3'd7;
      4'd7: b = 3'd4;
      4'd8: b = 3'd4;
      4'd9: b = 3'd5;
      4'd10: b = 3'd6;
      4'd11: b = 3'd7;
      default: b = 3'd1;
    endcase
    return b;
  endfunction

  function automatic poly_t poly_rom(input logic [7:0] code);
    poly_t p;
    case (code)
      8'd1:   p = {3'd3, 24'h083000};
      8'd2:   p = {3'd3, 24'h019000};
      8'd3:   p = {3'd4, 24'h198300};
      8'd4:   p = {3'd3, 24'h12a000};
      8'd6:   p = {3'd4, 24'h902a00};
      8'd7:   p = {3'd5, 24'h2a9830};
      8'd8:   p = {3'd3, 24'h3b2000};
      8'd9:   p = {3'd4, 24'h08b200};
      8'd11:  p = {3'd5, 24'h198b20};
      8'd12:  p = {3'd4, 24'h3ba100};
      8'd13:  p = {3'd5, 24'h08ba10};
      8'd14:  p = {3'd5, 24'h3ba900};
      8'd15:  p = {3'd4, 24'h98ba00};
      8'd16:  p = {3'd3, 24'h478000};
      8'd17:  p = {3'd4, 24'h473000};
      8'd19:  p = {3'd5, 24'h473190};
      8'd23:  p = {3'd6, 24'h2a9473};
      8'd25:  p = {3'd5, 24'hb20470};
      8'd27:  p = {3'd6, 24'h47b219};
      8'd29:  p = {3'd6, 24'h1047ba};
      8'd31:  p = {3'd5, 24'h47ba90};
      8'd32:  p = {3'd3, 24'h954000};
      8'd34:  p = {3'd4, 24'h015400};
      8'd35:  p = {3'd5, 24'h831540};
      8'd38:  p = {3'd5, 24'h5402a0};
      8'd39:  p = {3'd6, 24'h2a5483};
      8'd43:  p = {3'd6, 24'h21548b};
      8'd46:  p = {3'd6, 24'h5403ba};
      8'd47:  p = {3'd5, 24'h548ba0};
      8'd48:  p = {3'd4, 24'h957800};
      8'd49:  p = {3'd5, 24'h957300};
      8'd50:  p = {3'd5, 24'h015780};
      8'd51:  p = {3'd4, 24'h157300};
      8'd54:  p = {3'd6, 24'h802a57};
      8'd55:  p = {3'd5, 24'h2a5730};
      8'd57:  p = {3'd6, 24'h957b20};
      8'd59:  p = {3'd5, 24'hb21570};
      8'd63:  p = {3'd4, 24'hba5700};
      8'd64:  p = {3'd3, 24'ha65000};
      8'd68:  p = {3'd4, 24'h126500};
      8'd70:  p = {3'd5, 24'h902650};
      8'd71:  p = {3'd6, 24'h598326};
      8'd76:  p = {3'd5, 24'h6513b0};
      8'd77:  p = {3'd6, 24'h08b651};
      8'd78:  p = {3'd6, 24'h3b6590};
      8'd79:  p = {3'd5, 24'h6598b0};
      8'd96:  p = {3'd4, 24'ha64900};
      8'd98:  p = {3'd5, 24'ha64010};
      8'd99:  p = {3'd6, 24'h831a64};
      8'd100: p = {3'd5, 24'h126490};
      8'd102: p = {3'd4, 24'h026400};
      8'd103: p = {3'd5, 24'h832640};
      8'd108: p = {3'd6, 24'h913b64};
      8'd110: p = {3'd5, 24'h3b6400};
      8'd111: p = {3'd4, 24'h648b00};
      8'd112: p = {3'd5, 24'h789a60};
      8'd113: p = {3'd6, 24'h09a673};
      8'd114: p = {3'd6, 24'ha67801};
      8'd115: p = {3'd5, 24'ha67310};
      8'd116: p = {3'd6, 24'h126789};
      8'd118: p = {3'd5, 24'h780260};
      8'd119: p = {3'd4, 24'h732600};
      8'd127: p = {3'd3, 24'h7b6000};
      8'd128: p = {3'd3, 24'h76b000};
      8'd136: p = {3'd4, 24'h762300};
      8'd137: p = {3'd5, 24'h762080};
      8'd139: p = {3'd6, 24'h198762};
      8'd140: p = {3'd5, 24'ha13760};
      8'd141: p = {3'd6, 24'ha10876};
      8'd142: p = {3'd6, 24'h0376a9};
      8'd143: p = {3'd5, 24'h76a980};
      8'd144: p = {3'd4, 24'h6b8400};
      8'd145: p = {3'd5, 24'h3046b0};
      8'd147: p = {3'd6, 24'h946b31};
      8'd152: p = {3'd5, 24'h846230};
      8'd153: p = {3'd4, 24'h046200};
      8'd155: p = {3'd5, 24'h194620};
      8'd156: p = {3'd6, 24'h846a13};
      8'd157: p = {3'd5, 24'ha10460};
      8'd159: p = {3'd4, 24'ha94600};
      8'd176: p = {3'd5, 24'h6b8950};
      8'd177: p = {3'd6, 24'h30956b};
      8'd178: p = {3'd6, 24'h0156b8};
      8'd179: p = {3'd5, 24'h6b3150};
      8'd184: p = {3'd6, 24'h562389};
      8'd185: p = {3'd5, 24'h956200};
      8'd187: p = {3'd4, 24'h156200};
      8'd191: p = {3'd3, 24'ha56000};
      8'd192: p = {3'd4, 24'hb75a00};
      8'd196: p = {3'd5, 24'hb75120};
      8'd198: p = {3'd6, 24'h902b75};
      8'd200: p = {3'd5, 24'h2375a0};
      8'd201: p = {3'd6, 24'h875a20};
      8'd204: p = {3'd4, 24'h137500};
      8'd205: p = {3'd5, 24'h087510};
      8'd206: p = {3'd5, 24'h903750};
      8'd207: p = {3'd4, 24'h987500};
      8'd208: p = {3'd5, 24'h5ab840};
      8'd209: p = {3'd6, 24'h5ab304};
      8'd212: p = {3'd6, 24'h2b8451};
      8'd216: p = {3'd6, 24'h23845a};
      8'd217: p = {3'd5, 24'h5a2040};
      8'd220: p = {3'd5, 24'h845130};
      8'd221: p = {3'd4, 24'h045100};
      8'd223: p = {3'd3, 24'h945000};
      8'd224: p = {3'd5, 24'h49ab70};
      8'd226: p = {3'd6, 24'h1ab740};
      8'd228: p = {3'd6, 24'h4912b7};
      8'd230: p = {3'd5, 24'hb74020};
      8'd232: p = {3'd6, 24'h23749a};
      8'd236: p = {3'd5, 24'h491370};
      8'd238: p = {3'd4, 24'h403700};
      8'd239: p = {3'd3, 24'h487000};
      8'd240: p = {3'd4, 24'h9ab800};
      8'd241: p = {3'd5, 24'h309ab0};
      8'd242: p = {3'd5, 24'h01ab80};
      8'd243: p = {3'd4, 24'h31ab00};
      8'd244: p = {3'd5, 24'h12b890};
      8'd246: p = {3'd4, 24'h02b800};
      8'd247: p = {3'd3, 24'h32b000};
      8'd248: p = {3'd5, 24'h2389a0};
      8'd249: p = {3'd4, 24'h9a2000};
      8'd251: p = {3'd3, 24'h1a2000};
      8'd252: p = {3'd4, 24'h138900};
      8'd253: p = {3'd3, 24'h091000};
      8'd254: p = {3'd3, 24'h038000};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/bsp_frac.sv
module bsp_frac (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [bsp_pkg::DW-1:0] un,
  input  logic [bsp_pkg::DW-1:0] ud,
  input  bsp_pkg::vjob_t      job_in,
  output logic                out_valid,
  output logic [bsp_pkg::FB:0] t,
  output bsp_pkg::vjob_t      job_out
);
  import bsp_pkg::*;

  localparam int NS = QB + 1;

  logic          vld  [NS];
  logic [DW-1:0] rem  [NS];
  logic [DW-1:0] den  [NS];
  logic [QB-1:0] quo  [NS];
  logic          spec [NS];
  logic          one  [NS];
  vjob_t         job  [NS];
  logic [QB:0]   quo_inc;

  // Entry stage: a numerator that is not below the denominator clamps to 0 or 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= un;
      den[0]  <= ud;
      quo[0]  <= '0;
      spec[0] <= (ud == '0) || (un >= ud);
      one[0]  <= (un != '0);
      job[0]  <= job_in;
    end
  end

  // One restoring division step per stage.
  for (genvar i = 1; i < NS; i++) begin : g_step
    logic [DW:0] shl;
    logic [DW:0] dif;
    logic        ge;

    assign shl = {rem[i-1], 1'b0};
    assign dif = shl - {1'b0, den[i-1]};
    assign ge  = shl >= {1'b0, den[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? dif[DW-1:0] : shl[DW-1:0];
        den[i]  <= den[i-1];
        quo[i]  <= {quo[i-1][QB-2:0], ge};
        spec[i] <= spec[i-1];
        one[i]  <= one[i-1];
        job[i]  <= job[i-1];
      end
    end
  end

  assign quo_inc   = {1'b0, quo[NS-1]} + (QB+1)'(1);
  assign out_valid = vld[NS-1];
  assign job_out   = job[NS-1];
  assign t = spec[NS-1] ? (one[NS-1] ? (FB+1)'(1) << FB : '0) : quo_inc[QB:1];

endmodule

FILE: rtl/box_slice_polygon.sv
// Throughput: one vertex per cycle while the output is not stalled; an item holds the vertex
// sequencer for all vertices of its polygon (3 to 6), or one no-polygon vertex on a miss.
// The edge fraction divider is a 32-stage pipeline: an entry stage, then one quotient bit per stage.
// Reset (synchronous, active high) empties the pipeline and sets the view to +x.
module box_slice_polygon (
  input  logic            clk,
  input  logic            rst,
  input  logic            box_valid,
  output logic            box_stall,
  input  bsp_pkg::box_t   box,
  output logic            vert_valid,
  input  logic            vert_stall,
  output bsp_pkg::vert_t  vert,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import bsp_pkg::*;

  localparam logic [1:0] REG_VIEW_X = 2'd0;
  localparam logic [1:0] REG_VIEW_Y = 2'd1;
  localparam logic [1:0] REG_VIEW_Z = 2'd2;
  localparam logic signed [VW-1:0] VIEW_X_RESET = 16'sd16384;

  logic signed [VW-1:0] view_x, view_y, view_z;
  logic signed [VW-1:0] vw [3];

  logic en, fadv, seq_take;

  // Front pipeline.
  logic                 f1_valid;
  box_t                 f1;
  logic signed [CW-1:0] f1_lo [3];
  logic signed [CW-1:0] f1_hi [3];
  logic                 f2_valid;
  logic signed [CW-1:0] f2_lo [3];
  logic signed [CW-1:0] f2_hi [3];
  logic signed [PW-1:0] f2_plo [3];
  logic signed [PW-1:0] f2_phi [3];
  logic signed [DW-1:0] f2_plane;
  logic                 f3_valid;
  logic signed [CW-1:0] f3_lo [3];
  logic signed [CW-1:0] f3_hi [3];
  logic signed [DW-1:0] f3_dist [NCORNER];
  logic signed [DW-1:0] f3_plane;
  logic                 f4_valid;
  logic signed [CW-1:0] f4_lo [3];
  logic signed [CW-1:0] f4_hi [3];
  logic signed [DW-1:0] f4_un [NCORNER];
  logic signed [DW-1:0] f4_ud [NEDGE];
  logic [7:0]           f4_code;

  // Vertex sequencer.
  logic                 s_valid;
  logic [2:0]           s_k;
  logic [7:0]           s_code;
  poly_t                s_poly;
  logic signed [CW-1:0] s_lo [3];
  logic signed [CW-1:0] s_hi [3];
  logic signed [DW-1:0] s_un [NCORNER];
  logic signed [DW-1:0] s_ud [NEDGE];
  logic                 s_miss, s_last;
  logic [3:0]           s_edge;
  logic [2:0]           s_ea, s_eb, s_sa, s_sb;

  // Vertex pipeline.
  logic                 j1_valid;
  logic signed [DW-1:0] j1_un, j1_ud;
  vjob_t                j1_job;
  logic                 j2_valid;
  logic [DW-1:0]        j2_un, j2_ud;
  vjob_t                j2_job;
  logic                 d_valid;
  logic [FB:0]          d_t;
  vjob_t                d_job;
  logic signed [CW:0]   d_diff [3];
  logic                 l1_valid;
  logic [FB:0]          l1_t;
  logic [CW:0]          l1_mag [3];
  logic                 l1_neg [3];
  vjob_t                l1_job;
  logic                 l2_valid;
  logic [63:0]          l2_prod [3];
  logic                 l2_neg [3];
  vjob_t                l2_job;
  logic [CW:0]          o_off [3];
  logic [CW:0]          o_pos [3];

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= VIEW_X_RESET;
      view_y <= '0;
      view_z <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_VIEW_X: view_x <= pwdata[VW-1:0];
        REG_VIEW_Y: view_y <= pwdata[VW-1:0];
        REG_VIEW_Z: view_z <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VIEW_X: prdata = {16'b0, view_x};
      REG_VIEW_Y: prdata = {16'b0, view_y};
      REG_VIEW_Z: prdata = {16'b0, view_z};
      default:    prdata = '0;
    endcase
  end

  assign vw[0] = view_x;
  assign vw[1] = view_y;
  assign vw[2] = view_z;

  // The whole pipeline moves while the output register can take a vertex; the front
  // part also waits while the sequencer is still walking the previous polygon.
  assign en        = !vert_valid || !vert_stall;
  assign fadv      = en && (!f4_valid || seq_take);
  assign box_stall = !fadv;

  assign f1_lo[0] = f1.box_min_x;
  assign f1_lo[1] = f1.box_min_y;
  assign f1_lo[2] = f1.box_min_z;
  assign f1_hi[0] = f1.box_max_x;
  assign f1_hi[1] = f1.box_max_y;
  assign f1_hi[2] = f1.box_max_z;

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      f4_code[c] = f4_un[c][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
    end else if (fadv) begin
      f1_valid <= box_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0] sel;
    if (fadv) begin
      f1 <= box;
      for (int ax = 0; ax < 3; ax++) begin
        f2_lo[ax]  <= f1_lo[ax];
        f2_hi[ax]  <= f1_hi[ax];
        f2_plo[ax] <= PW'(f1_lo[ax]) * PW'(vw[ax]);
        f2_phi[ax] <= PW'(f1_hi[ax]) * PW'(vw[ax]);
        f3_lo[ax]  <= f2_lo[ax];
        f3_hi[ax]  <= f2_hi[ax];
        f4_lo[ax]  <= f3_lo[ax];
        f4_hi[ax]  <= f3_hi[ax];
      end
      f2_plane <= DW'(f1.plane_pos) <<< 14;
      f3_plane <= f2_plane;
      for (int c = 0; c < NCORNER; c++) begin
        sel = corner_sel(3'(c));
        f3_dist[c] <= DW'(sel[0] ? f2_phi[0] : f2_plo[0])
                    + DW'(sel[1] ? f2_phi[1] : f2_plo[1])
                    + DW'(sel[2] ? f2_phi[2] : f2_plo[2]);
        // Negative when the corner lies beyond the plane.
        f4_un[c] <= f3_plane - f3_dist[c];
      end
      for (int e = 0; e < NEDGE; e++) begin
        f4_ud[e] <= f3_dist[edge_b(4'(e))] - f3_dist[edge_a(4'(e))];
      end
    end
  end

  // Sequencer: one polygon vertex per cycle while the output is not stalled.
  assign s_miss   = (s_poly.count == 3'd0);
  assign s_last   = s_miss || (s_k == s_poly.count - 3'd1);
  assign seq_take = !s_valid || s_last;
  assign s_edge   = s_poly.edges[s_k];
  assign s_ea     = edge_a(s_edge);
  assign s_eb     = edge_b(s_edge);
  assign s_sa     = corner_sel(s_ea);
  assign s_sb     = corner_sel(s_eb);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_k     <= '0;
    end else if (en) begin
      if (seq_take) begin
        s_valid <= f4_valid;
        s_k     <= '0;
      end else begin
        s_k <= s_k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && seq_take) begin
      s_code <= f4_code;
      s_poly <= poly_rom(f4_code);
      s_lo   <= f4_lo;
      s_hi   <= f4_hi;
      s_un   <= f4_un;
      s_ud   <= f4_ud;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j1_valid <= 1'b0;
      j2_valid <= 1'b0;
      l1_valid <= 1'b0;
      l2_valid <= 1'b0;
      vert_valid <= 1'b0;
    end else if (en) begin
      j1_valid <= s_valid;
      j2_valid <= j1_valid;
      l1_valid <= d_valid;
      l2_valid <= l1_valid;
      vert_valid <= l2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j1_un <= s_un[s_ea];
      j1_ud <= s_ud[s_edge];
      for (int ax = 0; ax < 3; ax++) begin
        j1_job.pa[ax] <= s_sa[ax] ? s_hi[ax] : s_lo[ax];
        j1_job.pb[ax] <= s_sb[ax] ? s_hi[ax] : s_lo[ax];
      end
      j1_job.num    <= s_k;
      j1_job.code   <= s_code;
      j1_job.nopoly <= s_miss;
      j1_job.last   <= s_last;

      j2_un  <= j1_un[DW-1] ? DW'(-j1_un) : DW'(j1_un);
      j2_ud  <= j1_ud[DW-1] ? DW'(-j1_ud) : DW'(j1_ud);
      j2_job <= j1_job;
    end
  end

  bsp_frac u_frac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (j2_valid),
    .un        (j2_un),
    .ud        (j2_ud),
    .job_in    (j2_job),
    .out_valid (d_valid),
    .t         (d_t),
    .job_out   (d_job)
  );

  // Interpolation: a + sign(b - a) * round(|b - a| * t).
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      d_diff[ax] = (CW+1)'($signed(d_job.pb[ax])) - (CW+1)'($signed(d_job.pa[ax]));
      o_off[ax]  = l2_prod[ax][FB+CW:FB] + (CW+1)'(l2_prod[ax][FB-1]);
      o_pos[ax]  = l2_neg[ax] ? {1'b0, l2_job.pa[ax]} - o_off[ax]
                              : {1'b0, l2_job.pa[ax]} + o_off[ax];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_t   <= d_t;
      l1_job <= d_job;
      for (int ax = 0; ax < 3; ax++) begin
        l1_neg[ax] <= d_diff[ax][CW];
        l1_mag[ax] <= d_diff[ax][CW] ? (CW+1)'(-d_diff[ax]) : (CW+1)'(d_diff[ax]);
        l2_prod[ax] <= 64'(l1_mag[ax]) * 64'(l1_t);
        l2_neg[ax]  <= l1_neg[ax];
      end
      l2_job <= l1_job;

      if (l2_job.nopoly) begin
        vert.vert_x      <= '0;
        vert.vert_y      <= '0;
        vert.vert_z      <= '0;
        vert.vert_number <= '0;
      end else begin
        vert.vert_x      <= o_pos[0][CW-1:0];
        vert.vert_y      <= o_pos[1][CW-1:0];
        vert.vert_z      <= o_pos[2][CW-1:0];
        vert.vert_number <= l2_job.num;
      end
      vert.corner_code <= l2_job.code;
      vert.no_polygon  <= l2_job.nopoly;
      vert.last_vertex <= l2_job.last;
    end
  end

`ifndef ASSERT_OFF
  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_miss |-> s_k < s_poly.count)
    else $error("vertex counter ran past the polygon size");

  a_miss_shape: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert.no_polygon |-> vert.last_vertex && vert.vert_number == 3'd0)
    else $error("empty result is not a single final item");

  a_cut_code: assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert.no_polygon |-> vert.corner_code != 8'h00 && vert.corner_code != 8'hff)
    else $error("polygon vertex from a code with all corners on one side");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f4_valid && !seq_take |-> box_stall)
    else $error("new item taken while the sequencer is busy and the front is full");
`endif

endmodule

FILE: dv/tb_box_slice_polygon.sv
`timescale 1ns / 1ps

module tb_box_slice_polygon;
  import bsp_pkg::*;

  localparam logic [3:0] ADDR_VIEW_X = 4'd0;
  localparam logic [3:0] ADDR_VIEW_Y = 4'd4;
  localparam logic [3:0] ADDR_VIEW_Z = 4'd8;
  localparam logic [3:0] ADDR_SPARE  = 4'd12;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;

  // Corner to max-select (bit 0 x, bit 1 y, bit 2 z), and edge endpoints.
  localparam logic [2:0] CORNER_AXES [8] = '{0, 1, 3, 2, 4, 5, 7, 6};
  localparam int EDGE_FROM [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  localparam int EDGE_TO   [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

  // Vertex count in the top nibble, then up to six crossed edges in polygon order.
  localparam logic [27:0] SLICE_ROM [256] = '{
    28'h0000000, 28'h3083000, 28'h3019000, 28'h4198300,
    28'h312a000, 28'h0000000, 28'h4902a00, 28'h52a9830,
    28'h33b2000, 28'h408b200, 28'h0000000, 28'h5198b20,
    28'h43ba100, 28'h508ba10, 28'h53ba900, 28'h498ba00,
    28'h3478000, 28'h4473000, 28'h0000000, 28'h5473190,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h62a9473,
    28'h0000000, 28'h5b20470, 28'h0000000, 28'h647b219,
    28'h0000000, 28'h61047ba, 28'h0000000, 28'h547ba90,
    28'h3954000, 28'h0000000, 28'h4015400, 28'h5831540,
    28'h0000000, 28'h0000000, 28'h55402a0, 28'h62a5483,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h621548b,
    28'h0000000, 28'h0000000, 28'h65403ba, 28'h5548ba0,
    28'h4957800, 28'h5957300, 28'h5015780, 28'h4157300,
    28'h0000000, 28'h0000000, 28'h6802a57, 28'h52a5730,
    28'h0000000, 28'h6957b20, 28'h0000000, 28'h5b21570,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h4ba5700,
    28'h3a65000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h4126500, 28'h0000000, 28'h5902650, 28'h6598326,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h56513b0, 28'h608b651, 28'h63b6590, 28'h56598b0,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h4a64900, 28'h0000000, 28'h5a64010, 28'h6831a64,
    28'h5126490, 28'h0000000, 28'h4026400, 28'h5832640,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h6913b64, 28'h0000000, 28'h53b6400, 28'h4648b00,
    28'h5789a60, 28'h609a673, 28'h6a67801, 28'h5a67310,
    28'h6126789, 28'h0000000, 28'h5780260, 28'h4732600,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h37b6000,
    28'h376b000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h4762300, 28'h5762080, 28'h0000000, 28'h6198762,
    28'h5a13760, 28'h6a10876, 28'h60376a9, 28'h576a980,
    28'h46b8400, 28'h53046b0, 28'h0000000, 28'h6946b31,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h5846230, 28'h4046200, 28'h0000000, 28'h5194620,
    28'h6846a13, 28'h5a10460, 28'h0000000, 28'h4a94600,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h56b8950, 28'h630956b, 28'h60156b8, 28'h56b3150,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h6562389, 28'h5956200, 28'h0000000, 28'h4156200,
    28'h0000000, 28'h0000000, 28'h0000000, 28'h3a56000,
    28'h4b75a00, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h5b75120, 28'h0000000, 28'h6902b75, 28'h0000000,
    28'h52375a0, 28'h6875a20, 28'h0000000, 28'h0000000,
    28'h4137500, 28'h5087510, 28'h5903750, 28'h4987500,
    28'h55ab840, 28'h65ab304, 28'h0000000, 28'h0000000,
    28'h62b8451, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h623845a, 28'h55a2040, 28'h0000000, 28'h0000000,
    28'h5845130, 28'h4045100, 28'h0000000, 28'h3945000,
    28'h549ab70, 28'h0000000, 28'h61ab740, 28'h0000000,
    28'h64912b7, 28'h0000000, 28'h5b74020, 28'h0000000,
    28'h623749a, 28'h0000000, 28'h0000000, 28'h0000000,
    28'h5491370, 28'h0000000, 28'h4403700, 28'h3487000,
    28'h49ab800, 28'h5309ab0, 28'h501ab80, 28'h431ab00,
    28'h512b890, 28'h0000000, 28'h402b800, 28'h332b000,
    28'h52389a0, 28'h49a2000, 28'h0000000, 28'h31a2000,
    28'h4138900, 28'h3091000, 28'h3038000, 28'h0000000
  };

  typedef struct {
    box_t       b;
    bit         typed;
    logic [7:0] code;
    bit         miss;
  } slice_case_t;

  logic        clk;
  logic        rst;
  logic        box_valid;
  logic        box_stall;
  box_t        box;
  logic        vert_valid;
  logic        vert_stall;
  vert_t       vert;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic signed [15:0] view [3];
  vert_t vert_q [$];
  int    errors;
  int    boxes_sent;
  int    verts_seen;
  int    misses_seen;
  int    stall_left;
  int    idle_cycles;
  bit    hold_long;
  bit    send_quiet;
  bit    recv_quiet;

  box_slice_polygon i_dut (
    .clk, .rst, .box_valid, .box_stall, .box, .vert_valid, .vert_stall, .vert,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint corner_coord(input box_t b, input int c, input int ax);
    logic [2:0] s;
    s = CORNER_AXES[c];
    case (ax)
      0: return s[0] ? longint'(b.box_max_x) : longint'(b.box_min_x);
      1: return s[1] ? longint'(b.box_max_y) : longint'(b.box_min_y);
      default: return s[2] ? longint'(b.box_max_z) : longint'(b.box_min_z);
    endcase
  endfunction

  function automatic longint corner_dist(input box_t b, input int c);
    longint d;
    d = 0;
    for (int ax = 0; ax < 3; ax++) d += corner_coord(b, c, ax) * longint'(view[ax]);
    return d;
  endfunction

  // Edge parameter as unsigned Q1.30, rounded to nearest, ties upward.
  function automatic longint unsigned edge_frac(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    if (den == 0 || num >= den) return (num == 0) ? 0 : (64'd1 << 30);
    q = 0;
    r = num;
    for (int i = 0; i < 31; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint lerp(input longint a, input longint b2, input longint unsigned t);
    longint diff;
    longint unsigned m;
    longint unsigned off;
    diff = b2 - a;
    m = (diff < 0) ? longint'(-diff) : diff;
    off = (m * t + (64'd1 << 29)) >> 30;
    return (diff < 0) ? a - longint'(off) : a + longint'(off);
  endfunction

  // Queues the vertices that one box and plane must produce.
  function automatic void slice_box(input box_t b, output logic [7:0] code, output bit miss);
    longint cdist [8];
    longint plane;
    longint dn;
    longint dd;
    longint unsigned t;
    logic [27:0] entry;
    int n;
    int e;
    int ca;
    int cb;
    vert_t v;
    plane = longint'(b.plane_pos) * 16384;
    code = '0;
    for (int c = 0; c < 8; c++) begin
      cdist[c] = corner_dist(b, c);
      if (cdist[c] > plane) code[c] = 1'b1;
    end
    entry = SLICE_ROM[code];
    n = entry[27:24];
    miss = (n == 0 || n > 6);
    if (miss) begin
      v = '0;
      v.corner_code = code;
      v.no_polygon = 1'b1;
      v.last_vertex = 1'b1;
      vert_q = {vert_q, v};
      return;
    end
    for (int k = 0; k < n; k++) begin
      e = entry[23 - 4 * k -: 4] % 12;
      ca = EDGE_FROM[e];
      cb = EDGE_TO[e];
      dn = plane - cdist[ca];
      dd = cdist[cb] - cdist[ca];
      t = edge_frac((dn < 0) ? -dn : dn, (dd < 0) ? -dd : dd);
      v.vert_x = 32'(lerp(corner_coord(b, ca, 0), corner_coord(b, cb, 0), t));
      v.vert_y = 32'(lerp(corner_coord(b, ca, 1), corner_coord(b, cb, 1), t));
      v.vert_z = 32'(lerp(corner_coord(b, ca, 2), corner_coord(b, cb, 2), t));
      v.vert_number = 3'(k);
      v.corner_code = code;
      v.no_polygon = 1'b0;
      v.last_vertex = (k + 1 == n);
      vert_q = {vert_q, v};
    end
  endfunction

  function automatic int idle_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Mostly sane boxes with the plane between two of their corners; some pure noise.
  function automatic box_t random_box();
    box_t b;
    int sh;
    int r;
    longint d1;
    longint d2;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return b;
    end
    sh = (r < 3) ? 3 : 11;
    b.box_min_x = int'($urandom) >>> sh;
    b.box_min_y = int'($urandom) >>> sh;
    b.box_min_z = int'($urandom) >>> sh;
    b.box_max_x = b.box_min_x + int'($urandom_range(0, 1 << (30 - sh)));
    b.box_max_y = b.box_min_y + int'($urandom_range(0, 1 << (30 - sh)));
    b.box_max_z = b.box_min_z + int'($urandom_range(0, 1 << (30 - sh)));
    if ($urandom_range(0, 15) == 0) begin
      b.box_min_x = b.box_max_x;
      b.box_max_x = b.box_min_y;
    end
    d1 = corner_dist(b, $urandom_range(0, 7));
    d2 = corner_dist(b, $urandom_range(0, 7));
    if ($urandom_range(0, 7) == 0) b.plane_pos = 32'(d1 >>> 14);
    else b.plane_pos = 32'((d1 + ((d2 - d1) / 256) * $urandom_range(0, 256)) >>> 14);
    return b;
  endfunction

  task automatic write_view(input logic [3:0] addr, input logic signed [15:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = {{16{val[15]}}, val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (addr)
      ADDR_VIEW_X: view[0] = val;
      ADDR_VIEW_Y: view[1] = val;
      ADDR_VIEW_Z: view[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_view(input logic signed [15:0] vx, input logic signed [15:0] vy,
                          input logic signed [15:0] vz);
    write_view(ADDR_VIEW_X, vx);
    write_view(ADDR_VIEW_Y, vy);
    write_view(ADDR_VIEW_Z, vz);
  endtask

  // Entered at a rising edge or after reset; leaves at the edge that took the item.
  task automatic send_box(input box_t b, output logic [7:0] code, output bit miss);
    int gap;
    gap = idle_draw(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      box_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box = b;
    box_valid = 1'b1;
    do @(posedge clk); while (box_stall);
    slice_box(b, code, miss);
    boxes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    box_valid = 1'b0;
    while (vert_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    logic [7:0] code;
    bit miss;
    for (int i = 0; i < n; i++) send_box(random_box(), code, miss);
    drain();
  endtask

  // Receiver: after each item it takes, it stalls for a freshly drawn number of cycles.
  always @(negedge clk) begin
    vert_stall = hold_long || stall_left > 0;
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    vert_t want;
    if (!rst && vert_valid && !vert_stall) begin
      verts_seen++;
      if (vert.no_polygon) misses_seen++;
      if (vert_q.size() == 0) begin
        $display("%0t: unexpected vertex %p", $realtime, vert);
        errors++;
      end else begin
        want = vert_q.pop_front();
        if (vert.vert_x !== want.vert_x || vert.vert_y !== want.vert_y ||
            vert.vert_z !== want.vert_z || vert.vert_number !== want.vert_number ||
            vert.corner_code !== want.corner_code || vert.no_polygon !== want.no_polygon ||
            vert.last_vertex !== want.last_vertex) begin
          $display("%0t: vertex mismatch, expected %p, got %p", $realtime, want, vert);
          errors++;
        end
      end
      stall_left = idle_draw(recv_quiet);
    end
  end

  always @(posedge clk) begin
    if (rst || (box_valid && !box_stall) || (vert_valid && !vert_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    slice_case_t cases [$];
    logic [7:0] code;
    bit miss;
    rst = 1'b1;
    box_valid = 1'b0;
    box = '0;
    vert_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    boxes_sent = 0;
    verts_seen = 0;
    misses_seen = 0;
    stall_left = 0;
    idle_cycles = 0;
    hold_long = 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    view[0] = 16'sd16384;
    view[1] = 16'sd0;
    view[2] = 16'sd0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Under the reset view (+x), with codes read straight off the geometry.
    cases = '{
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, -32'sh10000}, 1, 8'd255, 1},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000}, 1, 8'd0, 1},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 1, 8'd0, 1},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h0}, 1, 8'd102, 0},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h8000}, 1, 8'd102, 0},
      '{'{32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 32'h8000}, 1, 8'd153, 0},
      '{'{32'h4000, 0, 0, 32'h4000, 32'h10000, 32'h10000, -32'sd1}, 1, 8'd255, 1},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h0}, 1, 8'd102, 0},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff}, 1, 8'd0, 1},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h80000000}, 1, 8'd102, 0},
      '{'{-32'sh30000, 32'h5555, 32'hffff, 32'h12345, 32'h7ffff, 32'h40000, 32'h1}, 0, 0, 0}
    };
    foreach (cases[i]) begin
      send_box(cases[i].b, code, miss);
      if (cases[i].typed && (code !== cases[i].code || miss !== cases[i].miss)) begin
        $display("%0t: case %0d predicted code %0d miss %0d, table says %0d miss %0d",
                 $realtime, i, code, miss, cases[i].code, cases[i].miss);
        errors++;
      end
    end
    drain();

    // A skewed view makes triangle and hexagon cuts of the box; the spare address must be ignored.
    set_view(16'sd9459, -16'sd9459, 16'sd9459);
    write_view(ADDR_SPARE, 16'sh7abc);
    cases = '{
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h1000}, 0, 0, 0},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, -32'sh1000}, 0, 0, 0},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h3000}, 0, 0, 0},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, -32'sh3000}, 0, 0, 0},
      '{'{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h0}, 0, 0, 0}
    };
    foreach (cases[i]) send_box(cases[i].b, code, miss);
    drain();

    // A zero view direction can never produce a polygon.
    set_view(16'sd0, 16'sd0, 16'sd0);
    send_box('{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h0}, code, miss);
    send_box('{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, -32'sd1}, code, miss);
    random_phase(10);

    set_view(16'sd11585, 16'sd6000, -16'sd9000);
    random_phase(60);

    // Receiver holds off while the sender keeps offering back to back.
    set_view(-16'sd8192, 16'sd13000, 16'sd5000);
    send_quiet = 1'b1;
    fork
      begin
        repeat (20) @(posedge clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end
    join_none
    random_phase(70);
    send_quiet = 1'b0;

    set_view(-16'sd32768, 16'sd32767, -16'sd32768);
    random_phase(60);

    set_view(16'sd32767, -16'sd32768, 16'sd32767);
    recv_quiet = 1'b1;
    random_phase(60);
    recv_quiet = 1'b0;

    for (int p = 0; p < 4; p++) begin
      set_view(16'($urandom), 16'($urandom), 16'($urandom));
      send_quiet = (p == 1);
      recv_quiet = (p == 2);
      random_phase(55);
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;

    $display("Sliced %0d boxes under eleven view settings; %0d vertices checked, %0d misses.",
             boxes_sent, verts_seen, misses_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
